>>> rtl/core/acl_pkg.sv
// ----------------------------------------------------------------------------
// ADC level calibration averager: shared package
// Types, codes and constants used by the front, the back, the divider and the
// top level of the calibration averager.
// ----------------------------------------------------------------------------
package acl_pkg;

    // Shared restoring divider: numerator and denominator widths.
    localparam int DIV_N_W   = 26;
    localparam int DIV_D_W   = 32;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    localparam logic [5:0]  MAX_LEVELS        = 6'd32;
    localparam logic [5:0]  LEVEL_LAST        = 6'd63;
    localparam logic [17:0] RATE_SAT          = 18'd255000;
    localparam logic [17:0] MS_PER_S          = 18'd1000;
    localparam logic [21:0] NOISE_TOTAL_MAX   = 22'h3FFFFF;
    localparam logic [23:0] RATE_TOTAL_MAX    = 24'hFFFFFF;
    localparam logic [15:0] SAMPLE_MIN_RESET  = 16'hFFFF;
    localparam logic [31:0] ELAPSED_MAX       = 32'hFFFF_FFFF;

    localparam logic [5:0]  STEP_COUNT_RESET  = 6'd8;
    localparam logic [7:0]  SAMPLES_RESET     = 8'd64;

    // Register index as seen on paddr[2].
    localparam logic REG_STEP_COUNT       = 1'b0;
    localparam logic REG_SAMPLES_PER_STEP = 1'b1;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_STEP   = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_TICK   = 2'd3
    } acl_op_t;

    typedef enum logic [2:0] {
        CMD_BEGIN  = 3'd0,
        CMD_STEP   = 3'd1,
        CMD_SAMPLE = 3'd2,
        CMD_TICK   = 3'd3,
        CMD_NOP    = 3'd4
    } acl_cmd_kind_t;

    typedef struct packed {
        acl_cmd_kind_t kind;
        logic [15:0]   sample;
    } acl_cmd_t;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_CLOSE  = 2'd1,
        KIND_FINISH = 2'd2
    } acl_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NOT_MARKING = 2'd1,
        STATUS_SAMPLING    = 2'd2
    } acl_status_t;

    typedef struct packed {
        acl_kind_t   kind;
        acl_status_t status;
        logic [5:0]  level_index;
        logic [15:0] level_mean;
        logic [15:0] noise;
        logic [17:0] rate_hz;
        logic        marking_flag;
        logic        sampling_flag;
        logic        completed_flag;
    } acl_result_t;

    typedef struct packed {
        logic [5:0] step_count;
        logic [7:0] samples_per_step;
    } acl_cfg_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } acl_div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quot;
    } acl_div_rsp_t;

endpackage

>>> rtl/core/adc_level_calibration_averager.sv
// ----------------------------------------------------------------------------
// ADC level calibration averager
// Front queue, command execution with a shared divider, and the APB
// configuration registers.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one result transaction. A begin,
// step command, millisecond tick or ordinary sample is registered in the
// front queue and then in the output register; one can be taken every cycle
// the result side keeps up and the back is not dividing. A sample that closes
// a level, and a step command that finishes a run, occupy the back for up to
// two passes through the shared one-bit-per-cycle divider (mean and rate, or
// averaged noise and averaged rate); the rate pass of a close is skipped when
// no time has elapsed. Up to two transactions queue in front of the back while
// it divides. The user must write step_count (address 0) and samples_per_step
// (address 4) only while the block is idle; the block does not enforce this.
module adc_level_calibration_averager
    import acl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic [1:0]  s_tuser,   // [1:0] op
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [7:2] level_index, [23:8] level_mean, [39:24] noise,
    // [57:40] rate_hz, [58] marking_flag, [59] sampling_flag,
    // [60] completed_flag, [63:61] zero
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] kind
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic         [5:0] step_count_reg;
    logic         [7:0] samples_reg;
    logic               cfg_write;
    acl_cfg_t           cfg;
    logic               q_valid;
    acl_cmd_t           q_cmd;
    logic               q_pop;
    acl_div_req_t       div_req;
    acl_div_rsp_t       div_rsp;
    logic               res_valid;
    acl_result_t        res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg <= STEP_COUNT_RESET;
            samples_reg    <= SAMPLES_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_STEP_COUNT) begin
                step_count_reg <= pwdata[5:0];
            end else begin
                samples_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SAMPLES_PER_STEP) ? 32'(samples_reg)
                                                       : 32'(step_count_reg);

    assign cfg.step_count       = step_count_reg;
    assign cfg.samples_per_step = samples_reg;

    acl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    acl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    acl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tvalid = res_valid;
    assign m_tuser  = res.kind;
    assign m_tdata  = {3'b000, res.completed_flag, res.sampling_flag, res.marking_flag,
                       res.rate_hz, res.noise, res.level_mean, res.level_index,
                       res.status};

endmodule

>>> rtl/core/acl_front.sv
// ----------------------------------------------------------------------------
// ADC level calibration averager: front
// Accepts input transactions, classifies them into commands and holds them in
// a two-entry queue for the back.
// ----------------------------------------------------------------------------
module acl_front
    import acl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        q_valid,
    output acl_cmd_t    q_cmd,
    input  logic        q_pop
);

    acl_cmd_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    acl_cmd_t   cmd_in;
    logic       push;
    logic       pop;

    always_comb begin
        cmd_in.sample = s_tdata;
        case (acl_op_t'(s_tuser))
            OP_BEGIN:  cmd_in.kind = CMD_BEGIN;
            OP_STEP:   cmd_in.kind = CMD_STEP;
            // A zero reading never changes state, so it is only acknowledged.
            OP_SAMPLE: cmd_in.kind = (s_tdata != 16'd0) ? CMD_SAMPLE : CMD_NOP;
            OP_TICK:   cmd_in.kind = CMD_TICK;
            default:   cmd_in.kind = CMD_NOP;
        endcase
    end

    assign s_tready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_cmd    = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

>>> rtl/core/acl_div.sv
// ----------------------------------------------------------------------------
// ADC level calibration averager: divider
// Restoring divider that produces one quotient bit per cycle. A start request
// loads the operands; done pulses once the quotient is complete.
// ----------------------------------------------------------------------------
module acl_div
    import acl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  acl_div_req_t req,
    output acl_div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_N_W-1:0]   quot_reg, quot_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   den_reg, den_next;
    logic [DIV_D_W:0]     shifted;
    logic                 fits;

    assign shifted = {rem_reg, quot_reg[DIV_N_W-1]};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_N_W - 1);
            quot_next = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end else if (busy_reg) begin
            rem_next  = fits ? DIV_D_W'(shifted - {1'b0, den_reg}) : shifted[DIV_D_W-1:0];
            quot_next = {quot_reg[DIV_N_W-2:0], fits};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

>>> rtl/core/acl_back.sv
// ----------------------------------------------------------------------------
// ADC level calibration averager: back
// Executes queued commands against the calibration state, runs the divisions
// of a step close or a run finish on the shared divider and holds the result
// in the output register.
// ----------------------------------------------------------------------------
module acl_back
    import acl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  acl_cfg_t     cfg,
    input  logic         q_valid,
    input  acl_cmd_t     q_cmd,
    output logic         q_pop,
    output acl_div_req_t div_req,
    input  acl_div_rsp_t div_rsp,
    output logic         res_valid,
    output acl_result_t  res,
    input  logic         res_ready
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV_A = 4'b0010,
        ST_DIV_B = 4'b0100,
        ST_DONE  = 4'b1000
    } acl_back_state_t;

    acl_back_state_t state_reg, state_next;

    logic        marking_reg, marking_next;
    logic        sampling_reg, sampling_next;
    logic        completed_reg, completed_next;
    logic [5:0]  level_reg, level_next;
    logic [23:0] sum_reg, sum_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] min_reg, min_next;
    logic [15:0] max_reg, max_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [21:0] noise_total_reg, noise_total_next;
    logic [23:0] rate_total_reg, rate_total_next;
    logic        finish_reg, finish_next;
    logic [15:0] qa_reg, qa_next;
    logic [17:0] qb_reg, qb_next;
    logic        out_valid_reg, out_valid_next;
    acl_result_t out_reg, out_next;

    logic        out_free;
    logic        take;
    logic        load_ack;
    acl_status_t ack_status;
    logic [5:0]  levels_eff;
    logic [15:0] step_noise;
    logic [17:0] rate_num;
    logic [22:0] noise_sum;
    logic [24:0] rate_sum;

    assign out_free   = !out_valid_reg || res_ready;
    assign take       = (state_reg == ST_IDLE) && q_valid && out_free;
    assign q_pop      = take;
    assign levels_eff = (cfg.step_count < MAX_LEVELS) ? cfg.step_count : MAX_LEVELS;
    assign step_noise = (count_reg != 8'd0 && max_reg >= min_reg) ? max_reg - min_reg : 16'd0;
    assign rate_num   = 18'(count_reg) * MS_PER_S;
    assign noise_sum  = {1'b0, noise_total_reg} + 23'(step_noise);
    assign rate_sum   = {1'b0, rate_total_reg} + 25'(qb_reg);

    always_comb begin
        state_next       = state_reg;
        marking_next     = marking_reg;
        sampling_next    = sampling_reg;
        completed_next   = completed_reg;
        level_next       = level_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        elapsed_next     = elapsed_reg;
        noise_total_next = noise_total_reg;
        rate_total_next  = rate_total_reg;
        finish_next      = finish_reg;
        qa_next          = qa_reg;
        qb_next          = qb_reg;
        out_valid_next   = out_valid_reg && !res_ready;
        out_next         = out_reg;
        div_req.start    = 1'b0;
        div_req.num      = '0;
        div_req.den      = '0;
        load_ack         = 1'b0;
        ack_status       = STATUS_OK;

        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    case (q_cmd.kind)
                        CMD_BEGIN: begin
                            marking_next     = 1'b1;
                            sampling_next    = 1'b0;
                            completed_next   = 1'b0;
                            level_next       = '0;
                            sum_next         = '0;
                            count_next       = '0;
                            min_next         = SAMPLE_MIN_RESET;
                            max_next         = '0;
                            elapsed_next     = '0;
                            noise_total_next = '0;
                            rate_total_next  = '0;
                            load_ack         = 1'b1;
                        end
                        CMD_STEP: begin
                            if (!marking_reg) begin
                                ack_status = STATUS_NOT_MARKING;
                                load_ack   = 1'b1;
                            end else if (sampling_reg) begin
                                ack_status = STATUS_SAMPLING;
                                load_ack   = 1'b1;
                            end else if (level_reg >= levels_eff) begin
                                // All levels are marked: average the run totals.
                                finish_next = 1'b1;
                                if (levels_eff != 6'd0) begin
                                    div_req.start = 1'b1;
                                    div_req.num   = DIV_N_W'(noise_total_reg);
                                    div_req.den   = DIV_D_W'(levels_eff);
                                    state_next    = ST_DIV_A;
                                end else begin
                                    qa_next    = '0;
                                    qb_next    = '0;
                                    state_next = ST_DONE;
                                end
                            end else begin
                                sum_next      = '0;
                                count_next    = '0;
                                min_next      = SAMPLE_MIN_RESET;
                                max_next      = '0;
                                elapsed_next  = '0;
                                sampling_next = 1'b1;
                                load_ack      = 1'b1;
                            end
                        end
                        CMD_SAMPLE: begin
                            if (!sampling_reg) begin
                                load_ack = 1'b1;
                            end else if (count_reg >= cfg.samples_per_step) begin
                                // This reading closes the level; it is not counted.
                                finish_next = 1'b0;
                                if (count_reg != 8'd0) begin
                                    div_req.start = 1'b1;
                                    div_req.num   = DIV_N_W'({sum_reg, 1'b0})
                                                  + DIV_N_W'(count_reg);
                                    div_req.den   = DIV_D_W'({count_reg, 1'b0});
                                    state_next    = ST_DIV_A;
                                end else begin
                                    qa_next    = '0;
                                    qb_next    = '0;
                                    state_next = ST_DONE;
                                end
                            end else begin
                                sum_next   = sum_reg + 24'(q_cmd.sample);
                                count_next = count_reg + 8'd1;
                                if (q_cmd.sample < min_reg) begin
                                    min_next = q_cmd.sample;
                                end
                                if (q_cmd.sample > max_reg) begin
                                    max_next = q_cmd.sample;
                                end
                                load_ack = 1'b1;
                            end
                        end
                        CMD_TICK: begin
                            if (elapsed_reg != ELAPSED_MAX) begin
                                elapsed_next = elapsed_reg + 32'd1;
                            end
                            load_ack = 1'b1;
                        end
                        default: begin
                            load_ack = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV_A: begin
                if (div_rsp.done) begin
                    qa_next = div_rsp.quot[15:0];
                    if (finish_reg) begin
                        div_req.start = 1'b1;
                        div_req.num   = DIV_N_W'(rate_total_reg);
                        div_req.den   = DIV_D_W'(levels_eff);
                        state_next    = ST_DIV_B;
                    end else if (elapsed_reg == 32'd0) begin
                        qb_next    = RATE_SAT;
                        state_next = ST_DONE;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.num   = DIV_N_W'(rate_num);
                        div_req.den   = elapsed_reg;
                        state_next    = ST_DIV_B;
                    end
                end
            end
            ST_DIV_B: begin
                if (div_rsp.done) begin
                    qb_next    = div_rsp.quot[17:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next    = 1'b1;
                    out_next.status   = STATUS_OK;
                    out_next.level_index = level_reg;
                    out_next.rate_hz  = qb_reg;
                    if (finish_reg) begin
                        out_next.kind       = KIND_FINISH;
                        out_next.level_mean = '0;
                        out_next.noise      = qa_reg;
                        noise_total_next    = '0;
                        rate_total_next     = '0;
                        completed_next      = 1'b1;
                        sampling_next       = 1'b0;
                        marking_next        = 1'b0;
                    end else begin
                        out_next.kind       = KIND_CLOSE;
                        out_next.level_mean = qa_reg;
                        out_next.noise      = step_noise;
                        sampling_next       = 1'b0;
                        rate_total_next     = (rate_sum > 25'(RATE_TOTAL_MAX))
                                            ? RATE_TOTAL_MAX : rate_sum[23:0];
                        noise_total_next    = (noise_sum > 23'(NOISE_TOTAL_MAX))
                                            ? NOISE_TOTAL_MAX : noise_sum[21:0];
                        if (level_reg < LEVEL_LAST) begin
                            level_next = level_reg + 6'd1;
                        end
                    end
                    out_next.marking_flag   = marking_next;
                    out_next.sampling_flag  = sampling_next;
                    out_next.completed_flag = completed_next;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_ack) begin
            out_valid_next          = 1'b1;
            out_next.kind           = KIND_ACK;
            out_next.status         = ack_status;
            out_next.level_index    = level_next;
            out_next.level_mean     = '0;
            out_next.noise          = '0;
            out_next.rate_hz        = '0;
            out_next.marking_flag   = marking_next;
            out_next.sampling_flag  = sampling_next;
            out_next.completed_flag = completed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            marking_reg     <= 1'b0;
            sampling_reg    <= 1'b0;
            completed_reg   <= 1'b0;
            level_reg       <= '0;
            sum_reg         <= '0;
            count_reg       <= '0;
            min_reg         <= SAMPLE_MIN_RESET;
            max_reg         <= '0;
            elapsed_reg     <= '0;
            noise_total_reg <= '0;
            rate_total_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            marking_reg     <= marking_next;
            sampling_reg    <= sampling_next;
            completed_reg   <= completed_next;
            level_reg       <= level_next;
            sum_reg         <= sum_next;
            count_reg       <= count_next;
            min_reg         <= min_next;
            max_reg         <= max_next;
            elapsed_reg     <= elapsed_next;
            noise_total_reg <= noise_total_next;
            rate_total_reg  <= rate_total_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        finish_reg <= finish_next;
        qa_reg     <= qa_next;
        qb_reg     <= qb_next;
        out_reg    <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

>>> sim/adc_level_calibration_averager_tb.sv
// ----------------------------------------------------------------------------
// ADC level calibration averager testbench
// Streams begin, step, sample and tick transactions into the averager and
// checks every result transaction against a cycle-free model of the
// calibration state. The model keeps its own copy of the configuration
// registers, which are written over APB between phases while the block is
// idle. A directed part covers the special cases. Randomized calibration
// runs follow under several register settings, with bursts of idling on
// both streams and one long result-side hold-off.
// ----------------------------------------------------------------------------
module adc_level_calibration_averager_tb;
    import acl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        acl_op_t     op;
        logic [15:0] smp;
    } cal_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Model state and its copy of the registers.
    logic        mk_active;
    logic        smp_active;
    logic        run_done;
    logic [5:0]  lvl;
    logic [23:0] acc_sum;
    logic [7:0]  acc_cnt;
    logic [15:0] acc_min;
    logic [15:0] acc_max;
    logic [31:0] ms_count;
    logic [21:0] noise_acc;
    logic [23:0] rate_acc;
    logic [5:0]  cfg_steps;
    logic [7:0]  cfg_sps;

    cal_item_t   stim_q[$];
    acl_result_t result_q[$];
    cal_item_t   tx_item;
    acl_result_t got;
    acl_result_t want;
    int          tx_gap       = 0;
    int          rx_gap       = 0;
    int          mismatch_cnt = 0;
    int          queued_items = 0;
    logic        quiet        = 1'b0;
    logic        pressure_go  = 1'b0;
    logic        hold_rx      = 1'b0;

    adc_level_calibration_averager i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic void clear_state();
        mk_active  = 1'b0;
        smp_active = 1'b0;
        run_done   = 1'b0;
        lvl        = '0;
        acc_sum    = '0;
        acc_cnt    = '0;
        acc_min    = SAMPLE_MIN_RESET;
        acc_max    = '0;
        ms_count   = '0;
        noise_acc  = '0;
        rate_acc   = '0;
    endfunction

    // Applies one accepted transaction to the model and returns its result.
    function automatic acl_result_t calib_predict(input acl_op_t op, input logic [15:0] smp);
        acl_result_t r;
        logic [5:0]  n_lv;
        logic [63:0] quo;
        logic [24:0] rate_sum;
        logic [22:0] noise_sum;
        r = '0;
        n_lv = (cfg_steps < MAX_LEVELS) ? cfg_steps : MAX_LEVELS;
        case (op)
            OP_BEGIN: begin
                clear_state();
                mk_active = 1'b1;
            end
            OP_STEP: begin
                if (!mk_active) begin
                    r.status = STATUS_NOT_MARKING;
                end else if (smp_active) begin
                    r.status = STATUS_SAMPLING;
                end else if (lvl >= n_lv) begin
                    if (n_lv != 0) begin
                        r.noise   = noise_acc / n_lv;
                        r.rate_hz = rate_acc / n_lv;
                    end
                    r.kind     = KIND_FINISH;
                    noise_acc  = '0;
                    rate_acc   = '0;
                    run_done   = 1'b1;
                    smp_active = 1'b0;
                    mk_active  = 1'b0;
                end else begin
                    acc_sum    = '0;
                    acc_cnt    = '0;
                    acc_min    = SAMPLE_MIN_RESET;
                    acc_max    = '0;
                    ms_count   = '0;
                    smp_active = 1'b1;
                end
            end
            OP_SAMPLE: begin
                if (smp_active && smp != 16'd0) begin
                    if (acc_cnt >= cfg_sps) begin
                        r.kind        = KIND_CLOSE;
                        r.level_index = lvl;
                        if (acc_cnt != 0) begin
                            quo = (64'(acc_sum) * 2 + 64'(acc_cnt)) / (64'(acc_cnt) * 2);
                            r.level_mean = quo[15:0];
                            r.noise = (acc_max >= acc_min) ? acc_max - acc_min : 16'd0;
                            if (ms_count == 0) begin
                                r.rate_hz = RATE_SAT;
                            end else begin
                                quo = (64'(acc_cnt) * 1000) / 64'(ms_count);
                                r.rate_hz = (quo > RATE_SAT) ? RATE_SAT : quo[17:0];
                            end
                        end
                        smp_active = 1'b0;
                        rate_sum  = rate_acc + r.rate_hz;
                        rate_acc  = (rate_sum > RATE_TOTAL_MAX) ? RATE_TOTAL_MAX : rate_sum[23:0];
                        noise_sum = noise_acc + r.noise;
                        noise_acc = (noise_sum > NOISE_TOTAL_MAX) ? NOISE_TOTAL_MAX
                                                                  : noise_sum[21:0];
                        if (lvl < LEVEL_LAST) lvl = lvl + 1'b1;
                    end else begin
                        acc_sum = acc_sum + smp;
                        if (smp < acc_min) acc_min = smp;
                        if (smp > acc_max) acc_max = smp;
                        acc_cnt = acc_cnt + 1'b1;
                    end
                end
            end
            default: begin
                if (ms_count != ELAPSED_MAX) ms_count = ms_count + 1;
            end
        endcase
        if (r.kind != KIND_CLOSE) r.level_index = lvl;
        r.marking_flag   = mk_active;
        r.sampling_flag  = smp_active;
        r.completed_flag = run_done;
        return r;
    endfunction

    function automatic string res_str(input acl_result_t r);
        return $sformatf("kind=%0d status=%0d idx=%0d mean=%0d noise=%0d rate=%0d mk/smp/done=%b%b%b",
                         r.kind, r.status, r.level_index, r.level_mean, r.noise, r.rate_hz,
                         r.marking_flag, r.sampling_flag, r.completed_flag);
    endfunction

    function automatic logic [15:0] level_sample(input int base, input int spread);
        int v;
        if ($urandom_range(0, 15) == 0) return 16'($urandom_range(1, 65535));
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 1) v = 1;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    task automatic push_item(input acl_op_t op, input logic [15:0] smp);
        cal_item_t it;
        it.op  = op;
        it.smp = smp;
        stim_q.push_back(it);
        queued_items++;
    endtask

    // One calibration run: begin, then per level a step command and enough
    // valid readings to close it, with ticks, zero readings and stray
    // commands mixed in. Without finish the run is abandoned.
    task automatic push_run(input int levels, input bit finish);
        int base;
        int spread;
        int tick_odds;
        push_item(OP_BEGIN, 16'($urandom));
        for (int l = 0; l < levels; l++) begin
            push_item(OP_STEP, 16'($urandom));
            if ($urandom_range(0, 7) == 0) push_item(OP_STEP, 16'($urandom));
            base      = $urandom_range(1, 65535);
            spread    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2000);
            tick_odds = $urandom_range(0, 4);
            for (int s = 0; s <= cfg_sps; s++) begin
                if (tick_odds != 0 && $urandom_range(1, 4) <= tick_odds) begin
                    push_item(OP_TICK, 16'($urandom));
                end
                if ($urandom_range(0, 15) == 0) push_item(OP_SAMPLE, 16'd0);
                push_item(OP_SAMPLE, level_sample(base, spread));
            end
            if ($urandom_range(0, 7) == 0) push_item(OP_SAMPLE, 16'($urandom_range(1, 65535)));
        end
        if (finish) push_item(OP_STEP, 16'($urandom));
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_STEP_COUNT) cfg_steps = val[5:0];
        else cfg_sps = val[7:0];
    endtask

    // Unused upper bits of the registers get random values.
    task automatic set_config(input logic [5:0] steps, input logic [7:0] sps);
        logic [31:0] v;
        v = $urandom;
        v[5:0] = steps;
        apb_write(REG_STEP_COUNT, v);
        v = $urandom;
        v[7:0] = sps;
        apb_write(REG_SAMPLES_PER_STEP, v);
    endtask

    task automatic drain();
        while (stim_q.size() != 0 || s_tvalid || result_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Input driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_gap != 0) begin
                s_tvalid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end else if (stim_q.size() != 0) begin
                tx_item = stim_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= tx_item.op;
                s_tdata  <= tx_item.smp;
                if (!quiet && $urandom_range(0, 5) == 0) tx_gap <= $urandom_range(1, 14);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result-side ready with random stall bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end else if (hold_rx) begin
            m_tready <= 1'b0;
        end else if (rx_gap != 0) begin
            m_tready <= 1'b0;
            rx_gap   <= rx_gap - 1;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) rx_gap <= $urandom_range(1, 14);
        end
    end

    // Long hold-off on the result side so that the block backs up.
    initial begin
        wait (pressure_go);
        @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    // Monitor: predicts on input acceptance and checks every result.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                result_q.push_back(calib_predict(acl_op_t'(s_tuser), s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got.kind           = acl_kind_t'(m_tuser);
                got.status         = acl_status_t'(m_tdata[1:0]);
                got.level_index    = m_tdata[7:2];
                got.level_mean     = m_tdata[23:8];
                got.noise          = m_tdata[39:24];
                got.rate_hz        = m_tdata[57:40];
                got.marking_flag   = m_tdata[58];
                got.sampling_flag  = m_tdata[59];
                got.completed_flag = m_tdata[60];
                if (result_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) $display("unexpected result: %s", res_str(got));
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("result mismatch at %0t\n  exp %s\n  got %s",
                                     $realtime, res_str(want), res_str(got));
                        end
                    end
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int steps_tab[6];
        int sps_tab[6];
        int budget_tab[6];
        int lvls;
        int n0;
        int pick;
        steps_tab  = '{3, 63, 1, 32, 5, 4};
        sps_tab    = '{4, 1, 255, 2, 8, 3};
        budget_tab = '{150, 100, 1, 100, 200, 150};
        clear_state();
        cfg_steps = STEP_COUNT_RESET;
        cfg_sps   = SAMPLES_RESET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: commands outside a run, double step, zero reading,
        // extreme readings, a close with elapsed time and one without.
        set_config(6'd1, 8'd2);
        push_item(OP_STEP, 16'h0000);
        push_item(OP_SAMPLE, 16'h1234);
        push_item(OP_TICK, 16'hFFFF);
        push_item(OP_BEGIN, 16'h0000);
        push_item(OP_STEP, 16'h0000);
        push_item(OP_STEP, 16'h0000);
        push_item(OP_SAMPLE, 16'h0000);
        push_item(OP_SAMPLE, 16'hFFFF);
        push_item(OP_TICK, 16'h0000);
        push_item(OP_SAMPLE, 16'h0001);
        push_item(OP_TICK, 16'h0000);
        push_item(OP_SAMPLE, 16'h8000);
        push_item(OP_SAMPLE, 16'h0042);
        push_item(OP_STEP, 16'h0000);
        push_item(OP_STEP, 16'h0000);
        push_item(OP_BEGIN, 16'hFFFF);
        push_item(OP_STEP, 16'h0000);
        push_item(OP_SAMPLE, 16'h0001);
        push_item(OP_SAMPLE, 16'h0002);
        push_item(OP_SAMPLE, 16'h0003);
        drain();
        // No levels at all, then levels that close without readings.
        set_config(6'd0, 8'd0);
        push_item(OP_BEGIN, 16'h0000);
        push_item(OP_STEP, 16'h0000);
        drain();
        set_config(6'd2, 8'd0);
        push_item(OP_BEGIN, 16'h0000);
        push_item(OP_STEP, 16'h0000);
        push_item(OP_SAMPLE, 16'h0005);
        push_item(OP_STEP, 16'h0000);
        push_item(OP_SAMPLE, 16'h0007);
        push_item(OP_STEP, 16'h0000);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) quiet = 1'b1;
            set_config(6'(steps_tab[ph]), 8'(sps_tab[ph]));
            lvls = (steps_tab[ph] < 32) ? steps_tab[ph] : 32;
            n0 = queued_items;
            while (queued_items - n0 < budget_tab[ph]) begin
                pick = $urandom_range(0, 7);
                if (pick < 6) begin
                    push_run(lvls, 1'b1);
                end else if (pick == 6) begin
                    push_run($urandom_range(0, lvls), 1'b0);
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        push_item(acl_op_t'($urandom_range(0, 3)),
                                  ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom));
                    end
                end
            end
            if (ph == 4) pressure_go = 1'b1;
            drain();
        end

        repeat (100) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/acl_pkg.sv
rtl/core/acl_front.sv
rtl/core/acl_div.sv
rtl/core/acl_back.sv
rtl/core/adc_level_calibration_averager.sv
sim/adc_level_calibration_averager_tb.sv
